// ----- rtl/ksm_pkg.sv -----
`timescale 1ns / 1ps
package ksm_pkg;

  localparam int TABLE_SLOTS            = 64;
  localparam int DEF_MAX_SEQUENCE_BYTES = 4;
  localparam int DEF_ENTRY_COUNT        = 45;
  localparam int INDEX_W                = 6;
  localparam int BYTE_W                 = 8;
  localparam int PC_W                   = 3;

  localparam logic [1:0] OP_NOP  = 2'd0;
  localparam logic [1:0] OP_TAKE = 2'd1;
  localparam logic [1:0] OP_CMD  = 2'd2;
  localparam logic [1:0] OP_RAW  = 2'd3;

  localparam logic [1:0] C_ALWAYS = 2'd0;
  localparam logic [1:0] C_EXACT  = 2'd1;
  localparam logic [1:0] C_HOLD   = 2'd2;
  localparam logic [1:0] C_LAST   = 2'd3;

  typedef struct packed {
    logic [1:0]      op;
    logic [1:0]      cond;
    logic [PC_W-1:0] t_true;
    logic [PC_W-1:0] t_false;
  } uword_t;

  typedef struct packed {
    logic in_valid;
    logic out_free;
    logic exact;
    logic hold;
    logic last;
  } status_t;

  typedef struct packed {
    logic in_ready;
    logic load_cmd;
    logic load_raw;
  } ctrl_t;

  typedef struct packed {
    logic [2:0]  len;
    logic [31:0] bytes;
  } seq_entry_t;

  function automatic seq_entry_t seq_entry(input logic [INDEX_W-1:0] e);
    seq_entry_t r;
    r = '{3'd0, 32'h0000_0000};
    case (e)
      6'd0:  r = '{3'd1, 32'h0000_0001};
      6'd1:  r = '{3'd1, 32'h0000_0002};
      6'd2:  r = '{3'd1, 32'h0000_0004};
      6'd3:  r = '{3'd1, 32'h0000_0005};
      6'd4:  r = '{3'd1, 32'h0000_0006};
      6'd5:  r = '{3'd1, 32'h0000_0008};
      6'd6:  r = '{3'd1, 32'h0000_000B};
      6'd7:  r = '{3'd1, 32'h0000_000E};
      6'd8:  r = '{3'd1, 32'h0000_0010};
      6'd9:  r = '{3'd1, 32'h0000_0012};
      6'd10: r = '{3'd1, 32'h0000_0013};
      6'd11: r = '{3'd1, 32'h0000_0015};
      6'd12: r = '{3'd1, 32'h0000_0016};
      6'd13: r = '{3'd1, 32'h0000_0017};
      6'd14: r = '{3'd1, 32'h0000_0019};
      6'd15: r = '{3'd2, 32'h0000_3118};
      6'd16: r = '{3'd2, 32'h0000_3218};
      6'd17: r = '{3'd2, 32'h0000_6918};
      6'd18: r = '{3'd2, 32'h0000_6B18};
      6'd19: r = '{3'd2, 32'h0000_6E18};
      6'd20: r = '{3'd2, 32'h0000_6F18};
      6'd21: r = '{3'd1, 32'h0000_0000};
      6'd22: r = '{3'd2, 32'h0000_0318};
      6'd23: r = '{3'd2, 32'h0000_0618};
      6'd24: r = '{3'd2, 32'h0000_0E18};
      6'd25: r = '{3'd2, 32'h0000_1318};
      6'd26: r = '{3'd2, 32'h0000_1718};
      6'd27: r = '{3'd2, 32'h0000_3D18};
      6'd28: r = '{3'd2, 32'h0000_631B};
      6'd29: r = '{3'd2, 32'h0000_691B};
      6'd30: r = '{3'd2, 32'h0000_6B1B};
      6'd31: r = '{3'd2, 32'h0000_6D1B};
      6'd32: r = '{3'd2, 32'h0000_6E1B};
      6'd33: r = '{3'd2, 32'h0000_6F1B};
      6'd34: r = '{3'd2, 32'h0000_761B};
      6'd35: r = '{3'd2, 32'h0000_671B};
      6'd36: r = '{3'd2, 32'h0000_771B};
      6'd37: r = '{3'd4, 32'h7E33_5B1B};
      6'd38: r = '{3'd1, 32'h0000_007F};
      6'd39: r = '{3'd3, 32'h0041_5B1B};
      6'd40: r = '{3'd3, 32'h0042_5B1B};
      6'd41: r = '{3'd3, 32'h0044_5B1B};
      6'd42: r = '{3'd3, 32'h0043_5B1B};
      6'd43: r = '{3'd4, 32'h7E36_5B1B};
      6'd44: r = '{3'd4, 32'h7E35_5B1B};
      default: r = '{3'd0, 32'h0000_0000};
    endcase
    return r;
  endfunction

endpackage

// ----- rtl/key_sequence_matcher.sv -----
`timescale 1ns / 1ps
// Key sequence matcher: folds keyboard bytes into command codes.
// Input channel s_axis_*: one key byte per beat in s_axis_tdata[7:0].
// Output channel m_axis_*: m_axis_tuser = 1 for a command, 0 for a replayed
// byte; m_axis_tdata carries entry_index [5:0] and raw_byte [13:6];
// m_axis_tlast marks the final beat caused by one input byte.
// Each byte is checked against a fixed table of up to four-byte sequences.
// A full match emits one command beat; a partial match emits nothing and
// waits; otherwise all pending bytes are replayed in order.
// A control-word sequencer steps once per cycle unless it waits on input or
// output. An extending byte passes intake, exact and hold; a command intake,
// exact and command; a replay intake, exact, hold, then one beat per cycle
// through the output register while free. Input is taken only at intake.
// Reset clears the pending count, the sequencer and the output valid flag.
// When the receiver stalls, the output register holds its beat and the
// sequencer waits in its emit step; a new input byte can still be taken
// while the last result waits.
module key_sequence_matcher
  import ksm_pkg::*;
#(
  parameter int MAX_SEQUENCE_BYTES = DEF_MAX_SEQUENCE_BYTES,
  parameter int ENTRY_COUNT        = DEF_ENTRY_COUNT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] key_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [5:0] entry_index, [13:6] raw_byte
  output logic        m_axis_tuser,   // [0] is_command
  output logic        m_axis_tlast
);

  localparam int CW = $clog2(MAX_SEQUENCE_BYTES + 1);
  localparam int IW = (MAX_SEQUENCE_BYTES > 1) ? $clog2(MAX_SEQUENCE_BYTES) : 1;

  logic [BYTE_W-1:0]      pending [MAX_SEQUENCE_BYTES];
  logic [CW-1:0]          count;
  logic [IW-1:0]          k;
  logic [TABLE_SLOTS-1:0] cand;
  logic [TABLE_SLOTS-1:0] cand_next;
  logic [TABLE_SLOTS-1:0] exact_vec;
  logic [TABLE_SLOTS-1:0] longer_vec;
  logic [INDEX_W-1:0]     hit_index;
  logic [3:0]             cnt4;
  logic                   take;
  logic                   replay_last;
  logic [BYTE_W-1:0]      key;
  status_t                status;
  ctrl_t                  ctrl;

  logic                   out_cmd;
  logic [INDEX_W-1:0]     out_index;
  logic [BYTE_W-1:0]      out_raw;
  logic                   out_last;

  assign key  = s_axis_tdata[BYTE_W-1:0];
  assign cnt4 = 4'(count);
  assign take = ctrl.in_ready && s_axis_tvalid;

  always_comb begin
    seq_entry_t ent;
    for (int e = 0; e < TABLE_SLOTS; e++) begin
      ent = seq_entry(INDEX_W'(e));
      cand_next[e]  = (e < ENTRY_COUNT) && ((count == '0) || cand[e]) &&
                      (4'(ent.len) > cnt4) &&
                      (ent.bytes[8*cnt4[1:0] +: 8] == key) &&
                      !((key == '0) && (count != '0));
      exact_vec[e]  = cand[e] && (4'(ent.len) == cnt4);
      longer_vec[e] = cand[e] && (4'(ent.len) > cnt4);
    end
  end

  always_comb begin
    hit_index = '0;
    for (int e = TABLE_SLOTS - 1; e >= 0; e--) begin
      if (exact_vec[e]) begin
        hit_index = INDEX_W'(e);
      end
    end
  end

  assign replay_last = ((CW'(k) + CW'(1)) == count);

  assign status.in_valid = s_axis_tvalid;
  assign status.out_free = !m_axis_tvalid || m_axis_tready;
  assign status.exact    = |exact_vec;
  assign status.hold     = (|longer_vec) && (count < CW'(MAX_SEQUENCE_BYTES));
  assign status.last     = replay_last;

  ksm_sequencer u_seq (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .ctrl   (ctrl)
  );

  always_ff @(posedge clk) begin
    if (take) begin
      pending[count[IW-1:0]] <= key;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      k     <= '0;
      cand  <= '0;
    end else begin
      if (take) begin
        count <= count + CW'(1);
        cand  <= cand_next;
      end
      if (ctrl.load_cmd) begin
        count <= '0;
      end
      if (ctrl.load_raw) begin
        if (replay_last) begin
          count <= '0;
          k     <= '0;
        end else begin
          k <= k + IW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (ctrl.load_cmd || ctrl.load_raw) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load_cmd) begin
      out_cmd   <= 1'b1;
      out_index <= hit_index;
      out_raw   <= '0;
      out_last  <= 1'b1;
    end else if (ctrl.load_raw) begin
      out_cmd   <= 1'b0;
      out_index <= '0;
      out_raw   <= pending[k];
      out_last  <= replay_last;
    end
  end

  assign s_axis_tready = ctrl.in_ready;
  assign m_axis_tdata  = {2'b00, out_raw, out_index};
  assign m_axis_tuser  = out_cmd;
  assign m_axis_tlast  = out_last;

  assert property (@(posedge clk) disable iff (rst)
    s_axis_tready |-> (count < CW'(MAX_SEQUENCE_BYTES)))
    else $error("intake with a full pending buffer");
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tlast && (m_axis_tdata[13:6] == 8'h00))
    else $error("command beat malformed");
  assert property (@(posedge clk) disable iff (rst)
    ctrl.load_cmd || (ctrl.load_raw && replay_last) |=> (count == '0) && (k == '0))
    else $error("pending buffer not cleared after final beat");
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tuser |-> (m_axis_tdata[5:0] == 6'd0))
    else $error("replayed beat carries an entry index");

endmodule

// ----- rtl/ksm_sequencer.sv -----
`timescale 1ns / 1ps
module ksm_sequencer
  import ksm_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  status_t status,
  output ctrl_t   ctrl
);

  localparam logic [PC_W-1:0] S_TAKE   = 3'd0;
  localparam logic [PC_W-1:0] S_EXACT  = 3'd1;
  localparam logic [PC_W-1:0] S_HOLD   = 3'd2;
  localparam logic [PC_W-1:0] S_REPLAY = 3'd3;
  localparam logic [PC_W-1:0] S_CMD    = 3'd4;

  function automatic uword_t ucode(input logic [PC_W-1:0] a);
    uword_t w;
    w = '{OP_NOP, C_ALWAYS, S_TAKE, S_TAKE};
    unique case (a)
      S_TAKE:   w = '{OP_TAKE, C_ALWAYS, S_EXACT,  S_EXACT};
      S_EXACT:  w = '{OP_NOP,  C_EXACT,  S_CMD,    S_HOLD};
      S_HOLD:   w = '{OP_NOP,  C_HOLD,   S_TAKE,   S_REPLAY};
      S_REPLAY: w = '{OP_RAW,  C_LAST,   S_TAKE,   S_REPLAY};
      S_CMD:    w = '{OP_CMD,  C_ALWAYS, S_TAKE,   S_TAKE};
      default:  w = '{OP_NOP,  C_ALWAYS, S_TAKE,   S_TAKE};
    endcase
    return w;
  endfunction

  logic [PC_W-1:0] pc;
  logic [PC_W-1:0] pc_next;
  uword_t          w;
  logic            blocked;
  logic            cond;

  assign w = ucode(pc);

  always_comb begin
    unique case (w.op)
      OP_TAKE:        blocked = !status.in_valid;
      OP_CMD, OP_RAW: blocked = !status.out_free;
      default:        blocked = 1'b0;
    endcase
    unique case (w.cond)
      C_EXACT: cond = status.exact;
      C_HOLD:  cond = status.hold;
      C_LAST:  cond = status.last;
      default: cond = 1'b1;
    endcase
    pc_next = blocked ? pc : (cond ? w.t_true : w.t_false);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= S_TAKE;
    end else begin
      pc <= pc_next;
    end
  end

  assign ctrl.in_ready = (w.op == OP_TAKE);
  assign ctrl.load_cmd = (w.op == OP_CMD) && status.out_free;
  assign ctrl.load_raw = (w.op == OP_RAW) && status.out_free;

  assert property (@(posedge clk) disable iff (rst)
    ctrl.load_raw && status.last |=> ctrl.in_ready)
    else $error("replay did not return to intake after final byte");
  assert property (@(posedge clk) disable iff (rst)
    $onehot0({ctrl.in_ready, ctrl.load_cmd, ctrl.load_raw}))
    else $error("more than one control action in one step");
  assert property (@(posedge clk) disable iff (rst)
    ctrl.load_cmd |=> ctrl.in_ready)
    else $error("command step not followed by intake");

endmodule

// ----- tb/sv/key_sequence_matcher_checker.sv -----
`timescale 1ns / 1ps
module key_sequence_matcher_checker
  import ksm_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] key_byte
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [15:0] m_axis_tdata,   // [5:0] entry_index, [13:6] raw_byte
  input  logic        m_axis_tuser,   // [0] is_command
  input  logic        m_axis_tlast,
  output int          mismatch_count,
  output int          result_backlog
);

  typedef struct packed {
    logic                is_command;
    logic [INDEX_W-1:0]  entry_index;
    logic [BYTE_W-1:0]   raw_byte;
    logic                last_beat;
  } key_beat_t;

  key_beat_t         expected_beats [$];
  logic [BYTE_W-1:0] held_keys [DEF_MAX_SEQUENCE_BYTES];
  int                held_count = 0;
  int                fail_total = 0;

  // {length, bytes with the first key in the top byte}
  function automatic logic [34:0] key_entry(input int e);
    logic [34:0] r;
    r = '0;
    case (e)
      0:  r = {3'd1, 32'h0100_0000};
      1:  r = {3'd1, 32'h0200_0000};
      2:  r = {3'd1, 32'h0400_0000};
      3:  r = {3'd1, 32'h0500_0000};
      4:  r = {3'd1, 32'h0600_0000};
      5:  r = {3'd1, 32'h0800_0000};
      6:  r = {3'd1, 32'h0B00_0000};
      7:  r = {3'd1, 32'h0E00_0000};
      8:  r = {3'd1, 32'h1000_0000};
      9:  r = {3'd1, 32'h1200_0000};
      10: r = {3'd1, 32'h1300_0000};
      11: r = {3'd1, 32'h1500_0000};
      12: r = {3'd1, 32'h1600_0000};
      13: r = {3'd1, 32'h1700_0000};
      14: r = {3'd1, 32'h1900_0000};
      15: r = {3'd2, 32'h1831_0000};
      16: r = {3'd2, 32'h1832_0000};
      17: r = {3'd2, 32'h1869_0000};
      18: r = {3'd2, 32'h186B_0000};
      19: r = {3'd2, 32'h186E_0000};
      20: r = {3'd2, 32'h186F_0000};
      21: r = {3'd1, 32'h0000_0000};
      22: r = {3'd2, 32'h1803_0000};
      23: r = {3'd2, 32'h1806_0000};
      24: r = {3'd2, 32'h180E_0000};
      25: r = {3'd2, 32'h1813_0000};
      26: r = {3'd2, 32'h1817_0000};
      27: r = {3'd2, 32'h183D_0000};
      28: r = {3'd2, 32'h1B63_0000};
      29: r = {3'd2, 32'h1B69_0000};
      30: r = {3'd2, 32'h1B6B_0000};
      31: r = {3'd2, 32'h1B6D_0000};
      32: r = {3'd2, 32'h1B6E_0000};
      33: r = {3'd2, 32'h1B6F_0000};
      34: r = {3'd2, 32'h1B76_0000};
      35: r = {3'd2, 32'h1B67_0000};
      36: r = {3'd2, 32'h1B77_0000};
      37: r = {3'd4, 32'h1B5B_337E};
      38: r = {3'd1, 32'h7F00_0000};
      39: r = {3'd3, 32'h1B5B_4100};
      40: r = {3'd3, 32'h1B5B_4200};
      41: r = {3'd3, 32'h1B5B_4400};
      42: r = {3'd3, 32'h1B5B_4300};
      43: r = {3'd4, 32'h1B5B_367E};
      44: r = {3'd4, 32'h1B5B_357E};
      default: r = '0;
    endcase
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    fail_total++;
  endtask

  task automatic decode_key_byte(input logic [BYTE_W-1:0] key);
    int          n;
    bit          prefix;
    bit          same;
    logic [34:0] ent;
    logic [2:0]  len;
    logic [31:0] seq;
    key_beat_t   beat;
    n      = (held_count >= DEF_MAX_SEQUENCE_BYTES) ? 0 : held_count;
    prefix = 1'b0;
    held_keys[n] = key;
    n++;
    // a zero key after the first position can never match
    if (!(key == 8'h00 && n > 1)) begin
      for (int e = 0; e < DEF_ENTRY_COUNT; e++) begin
        ent = key_entry(e);
        len = ent[34:32];
        seq = ent[31:0];
        if (len == 0 || n > len) continue;
        same = 1'b1;
        for (int i = 0; i < n; i++)
          if (held_keys[i] != seq[31-8*i -: 8]) same = 1'b0;
        if (!same) continue;
        if (n == len) begin
          beat = '{1'b1, INDEX_W'(e), 8'h00, 1'b1};
          expected_beats.push_back(beat);
          held_count = 0;
          return;
        end
        prefix = 1'b1;
      end
    end
    if (prefix && n < DEF_MAX_SEQUENCE_BYTES) begin
      held_count = n;
      return;
    end
    for (int k = 0; k < n; k++) begin
      beat = '{1'b0, '0, held_keys[k], (k == n - 1)};
      expected_beats.push_back(beat);
    end
    held_count = 0;
  endtask

  always @(posedge clk) begin
    key_beat_t want;
    if (rst) begin
      held_count = 0;
      expected_beats.delete();
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_beats.size() == 0) begin
          report_mismatch($sformatf("unexpected beat user=%0b data=%04h last=%0b",
                                    m_axis_tuser, m_axis_tdata, m_axis_tlast));
        end else begin
          want = expected_beats.pop_front();
          if (m_axis_tuser !== want.is_command)
            report_mismatch($sformatf("is_command got %0b want %0b",
                                      m_axis_tuser, want.is_command));
          if (m_axis_tdata[5:0] !== want.entry_index)
            report_mismatch($sformatf("entry_index got %0d want %0d",
                                      m_axis_tdata[5:0], want.entry_index));
          if (m_axis_tdata[13:6] !== want.raw_byte)
            report_mismatch($sformatf("raw_byte got %02h want %02h",
                                      m_axis_tdata[13:6], want.raw_byte));
          if (m_axis_tlast !== want.last_beat)
            report_mismatch($sformatf("last got %0b want %0b",
                                      m_axis_tlast, want.last_beat));
        end
      end
      if (s_axis_tvalid && s_axis_tready) decode_key_byte(s_axis_tdata);
    end
    result_backlog <= expected_beats.size();
    mismatch_count <= fail_total;
  end

endmodule

// ----- tb/sv/tb_key_sequence_matcher.sv -----
`timescale 1ns / 1ps
module tb_key_sequence_matcher;
  import ksm_pkg::*;

  localparam int RANDOM_KEYS = 400;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 20;

  localparam logic [7:0] DIRECTED_KEYS [27] = '{
    8'h00, 8'h01, 8'h19, 8'hFF, 8'h7F,
    8'h1B, 8'h5B, 8'h33, 8'h7E,
    8'h18, 8'h03,
    8'h1B, 8'h63,
    8'h1B, 8'h5B, 8'h41,
    8'h18, 8'h13,
    8'h18, 8'h00,
    8'h1B, 8'h5B, 8'h00,
    8'h1B, 8'h5B, 8'h33, 8'h41
  };
  localparam logic [7:0] SINGLE_KEYS [17] = '{
    8'h01, 8'h02, 8'h04, 8'h05, 8'h06, 8'h08, 8'h0B, 8'h0E, 8'h10,
    8'h12, 8'h13, 8'h15, 8'h16, 8'h17, 8'h19, 8'h00, 8'h7F
  };
  localparam logic [7:0] CTRL_X_KEYS [12] = '{
    8'h31, 8'h32, 8'h69, 8'h6B, 8'h6E, 8'h6F, 8'h03, 8'h06, 8'h0E,
    8'h13, 8'h17, 8'h3D
  };
  localparam logic [7:0] ESC_KEYS [9] = '{
    8'h63, 8'h69, 8'h6B, 8'h6D, 8'h6E, 8'h6F, 8'h76, 8'h67, 8'h77
  };
  localparam logic [7:0] CSI_KEYS [7] = '{
    8'h41, 8'h42, 8'h43, 8'h44, 8'h33, 8'h35, 8'h36
  };

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'h00;   // [7:0] key_byte
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;           // [5:0] entry_index, [13:6] raw_byte
  logic        m_axis_tuser;           // [0] is_command
  logic        m_axis_tlast;

  int mismatch_count;
  int result_backlog;
  int cycle_count = 0;
  int keys_sent = 0;
  int burst_left = 0;
  int calm_left = 0;
  int stall_left = 0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  key_sequence_matcher u_top (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  key_sequence_matcher_checker u_checker (
    .clk            (clk),
    .rst            (rst),
    .s_axis_tvalid  (s_axis_tvalid),
    .s_axis_tready  (s_axis_tready),
    .s_axis_tdata   (s_axis_tdata),
    .m_axis_tvalid  (m_axis_tvalid),
    .m_axis_tready  (m_axis_tready),
    .m_axis_tdata   (m_axis_tdata),
    .m_axis_tuser   (m_axis_tuser),
    .m_axis_tlast   (m_axis_tlast),
    .mismatch_count (mismatch_count),
    .result_backlog (result_backlog)
  );

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  always @(posedge clk) begin
    int pick;
    if (calm_left > 0) begin
      calm_left--;
      m_axis_tready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      m_axis_tready <= 1'b0;
    end else begin
      pick = $urandom_range(0, 99);
      if (pick < 3) calm_left = $urandom_range(20, 120);
      else if (pick < 8) stall_left = $urandom_range(10, 40);
      else if (pick < 35) stall_left = $urandom_range(0, 3);
      m_axis_tready <= (pick < 3) || (pick >= 35);
    end
  end

  function automatic int key_gap();
    int pick;
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    pick = $urandom_range(0, 99);
    if (pick < 4) begin
      burst_left = $urandom_range(10, 40);
      return 0;
    end
    if (pick < 50) return 0;
    if (pick < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic send_key(input logic [7:0] key);
    int gap;
    gap = key_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= key;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    keys_sent++;
  endtask

  // mostly well-formed with an occasional wrong tail byte
  function automatic logic [7:0] near_key(input logic [7:0] good, input int odds);
    if ($urandom_range(0, 99) < odds) return good;
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic send_random_sequence();
    int         pick;
    logic [7:0] third;
    pick = $urandom_range(0, 99);
    if (pick < 15) begin
      send_key(8'($urandom_range(0, 255)));
    end else if (pick < 35) begin
      send_key(SINGLE_KEYS[$urandom_range(0, 16)]);
    end else if (pick < 55) begin
      send_key(8'h18);
      send_key(near_key(CTRL_X_KEYS[$urandom_range(0, 11)], 80));
    end else if (pick < 75) begin
      send_key(8'h1B);
      send_key(near_key(ESC_KEYS[$urandom_range(0, 8)], 80));
    end else begin
      send_key(8'h1B);
      send_key(near_key(8'h5B, 90));
      third = near_key(CSI_KEYS[$urandom_range(0, 6)], 85);
      send_key(third);
      if (third == 8'h33 || third == 8'h35 || third == 8'h36)
        send_key(near_key(8'h7E, 85));
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (DIRECTED_KEYS[i]) send_key(DIRECTED_KEYS[i]);
    while (keys_sent < $size(DIRECTED_KEYS) + RANDOM_KEYS) send_random_sequence();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (result_backlog != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && result_backlog == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ----- key_sequence_matcher.f -----
rtl/ksm_pkg.sv
rtl/ksm_sequencer.sv
rtl/key_sequence_matcher.sv
tb/sv/key_sequence_matcher_checker.sv
tb/sv/tb_key_sequence_matcher.sv
